// ===== sv/positional_list_engine_core_assert.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Next-cycle implication, checked out of reset.
`define PLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("list engine sequencing check failed");

`endif

// ===== sv/ple_pkg.sv =====
// Package: sizes, codes, transfer structs and word helpers of the list engine.
`default_nettype none
package ple_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ACT_W      = 3;
    localparam int POS_W      = 8;
    localparam int VAL_W      = 32;
    localparam int ICNT_W     = 9;
    localparam int ST_W       = 3;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic [POS_W-1:0]        found_position;
        logic [ICNT_W-1:0]       item_count;
        logic [ST_W-1:0]         status;
    } t_rsp;

    // Narrow an input value to a stored word
    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [VAL_W-1:0] v);
        logic [63:0] w;
        w = 64'($signed(v));
        return w[DATA_WIDTH-1:0];
    endfunction

    // Sign-extend a stored word to the output width
    function automatic logic [VAL_W-1:0] from_word(input logic [DATA_WIDTH-1:0] d);
        logic [63:0] w;
        w = 64'($signed(d));
        return w[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/positional_list_engine_core.sv =====
// Top level: ordered word list in a single-port-write memory with a count.
// Usage: one request transfer on i_in_* (action, position, value_in) gives
// exactly one response transfer on o_out_* (value_out, found_position,
// item_count, status). A transfer happens when valid is high and stall low.
// The engine takes one request at a time; o_in_stall is high from the
// transfer until the response is placed in the output register.
// Push, insert at the tail, and refused or bad requests go straight to the
// response; pop and read pass through a read of the store; insert before
// position p moves the words from p up one place, top first, then writes
// the new word; remove at position p captures that word and moves the later
// words down; find checks words from the front until a match or the end.
// The store gives one read and one write per cycle, so insert and remove
// move one word per cycle and find checks one per cycle.
// A response waiting under i_out_stall holds; the next request can still
// be taken and is worked on, finishing once the output register frees.
// Reset (synchronous, active low) empties the list and drops any pending
// response. The store itself is not cleared; no unwritten entry is ever read.
`default_nettype none
`include "positional_list_engine_core_assert.svh"
module positional_list_engine_core
    import ple_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_req i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_rsp      o_out_data,
    input  wire logic i_out_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INS_SHIFT,
        S_INS_PUT,
        S_REM,
        S_FIND,
        S_RESP
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic                  r_first, n_first;
    t_rsp                  r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;

    // Store and its ports
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic                  rd_en, wr_en;
    logic [ADDR_W-1:0]     rd_addr, wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [CMP_W-1:0]      pos_c, cnt_c;
    logic                  full, empty, out_free;

    assign pos_c    = CMP_W'(i_in_data.position);
    assign cnt_c    = CMP_W'(r_count);
    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign out_free = !r_out_valid || !i_out_stall;

    // Sequence the request
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_val       = r_val;
        n_first     = r_first;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pos                = ADDR_W'(i_in_data.position);
                    n_val                = to_word(i_in_data.value_in);
                    n_res.value_out      = '0;
                    n_res.found_position = '0;
                    n_res.item_count     = ICNT_W'(r_count);
                    n_res.status         = ST_OK;
                    n_state              = S_RESP;
                    unique case (i_in_data.action)
                        ACT_PUSH: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                wr_en                = 1'b1;
                                wr_addr              = ADDR_W'(r_count);
                                wr_data              = to_word(i_in_data.value_in);
                                n_count              = r_count + 1'b1;
                                n_res.found_position = POS_W'(r_count);
                                n_res.item_count     = ICNT_W'(r_count + 1'b1);
                            end
                        end
                        ACT_POP: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = ADDR_W'(r_count - 1'b1);
                                n_count = r_count - 1'b1;
                                n_state = S_READ;
                            end
                        end
                        ACT_READ: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else if (pos_c >= cnt_c) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = ADDR_W'(i_in_data.position);
                                n_state = S_READ;
                            end
                        end
                        ACT_INSERT: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else if (pos_c > cnt_c) begin
                                n_res.status = ST_RANGE;
                            end else if (pos_c == cnt_c) begin
                                // Insert at the tail: a plain append
                                wr_en                = 1'b1;
                                wr_addr              = ADDR_W'(r_count);
                                wr_data              = to_word(i_in_data.value_in);
                                n_count              = r_count + 1'b1;
                                n_res.found_position = i_in_data.position;
                                n_res.item_count     = ICNT_W'(r_count + 1'b1);
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = ADDR_W'(r_count - 1'b1);
                                n_idx   = ADDR_W'(r_count - 1'b1);
                                n_state = S_INS_SHIFT;
                            end
                        end
                        ACT_REMOVE: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else if (pos_c >= cnt_c) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = ADDR_W'(i_in_data.position);
                                n_idx   = ADDR_W'(i_in_data.position);
                                n_first = 1'b1;
                                n_state = S_REM;
                            end
                        end
                        ACT_FIND: begin
                            if (empty) begin
                                n_res.status = ST_NOTFOUND;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = S_FIND;
                            end
                        end
                        default: begin
                            n_res.status = ST_RANGE;
                        end
                    endcase
                end
            end

            // Return the word read for pop or read
            S_READ: begin
                n_res.value_out  = from_word(r_rdata);
                n_res.item_count = ICNT_W'(r_count);
                n_state          = S_RESP;
            end

            // Move words up one place, top first
            S_INS_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx + 1'b1;
                wr_data = r_rdata;
                if (r_idx == r_pos) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = r_idx - 1'b1;
                end
            end

            // Drop the new word into the gap
            S_INS_PUT: begin
                wr_en                = 1'b1;
                wr_addr              = r_pos;
                wr_data              = r_val;
                n_count              = r_count + 1'b1;
                n_res.found_position = POS_W'(r_pos);
                n_res.item_count     = ICNT_W'(r_count + 1'b1);
                n_state              = S_RESP;
            end

            // Capture the removed word, then move later words down
            S_REM: begin
                n_first = 1'b0;
                if (r_first) begin
                    n_res.value_out = from_word(r_rdata);
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx - 1'b1;
                    wr_data = r_rdata;
                end
                if (CNT_W'(r_idx) == r_count - 1'b1) begin
                    n_count          = r_count - 1'b1;
                    n_res.item_count = ICNT_W'(r_count - 1'b1);
                    n_state          = S_RESP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end

            // Compare one word per cycle from the front
            S_FIND: begin
                if (r_rdata == r_val) begin
                    n_res.found_position = POS_W'(r_idx);
                    n_res.status         = ST_OK;
                    n_state              = S_RESP;
                end else if (CNT_W'(r_idx) == r_count - 1'b1) begin
                    n_res.status = ST_NOTFOUND;
                    n_state      = S_RESP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end

            // Hand the response to the output register once it is free
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, count, working registers and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_first <= n_first;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PLE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `PLE_ASSERT_NOW(a_full_count, o_out_valid && o_out_data.status == ST_FULL,
        o_out_data.item_count == ICNT_W'(DEPTH))
    `PLE_ASSERT_NOW(a_empty_count, o_out_valid && o_out_data.status == ST_EMPTY,
        o_out_data.item_count == '0)
    `PLE_ASSERT_NEXT(a_busy_after_take, i_in_valid && !o_in_stall, r_state != S_IDLE)

endmodule
`default_nettype wire
